### design/tw_pkg.sv
package tw_pkg;

  // Default store geometry.
  localparam int MAX_COLS_DEF  = 128;
  localparam int MAX_LINES_DEF = 64;

  // One cell: character in the low byte, attribute in the high byte.
  localparam int CELL_W = 16;

  // Stream and register port widths.
  localparam int IN_DW  = 32;
  localparam int OUT_DW = 32;
  localparam int CFG_AW = 4;
  localparam int CFG_DW = 32;

  // Register map, one 32-bit word per register.
  typedef enum logic [1:0] {
    REG_MODE      = 2'd0,
    REG_ATTR      = 2'd1,
    REG_LAST_COL  = 2'd2,
    REG_LAST_LINE = 2'd3
  } reg_idx_t;

  // Register reset values.
  localparam logic [3:0] MODE_RESET      = 4'd4;
  localparam logic [7:0] ATTR_RESET      = 8'd0;
  localparam logic [6:0] LAST_COL_RESET  = 7'd79;
  localparam logic [5:0] LAST_LINE_RESET = 6'd23;

  // Operation codes.
  localparam logic OP_PUT  = 1'b0;
  localparam logic OP_READ = 1'b1;

  // Character codes with a meaning of their own.
  localparam logic [7:0] CH_BS    = 8'h08;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_BANG  = 8'h21;
  localparam logic [7:0] CH_QUEST = 8'h3F;
  localparam logic [7:0] CH_AT    = 8'h40;
  localparam logic [7:0] CH_CARET = 8'h5E;
  localparam logic [7:0] CH_TILDE = 8'h7E;
  localparam logic [7:0] CH_ALL   = 8'hFF;

  // Tab stops every eight columns.
  localparam logic [7:0] TAB_MASK = 8'hF8;
  localparam logic [7:0] TAB_STEP = 8'd8;

  // Configuration as seen by the engine.
  typedef struct packed {
    logic       scroll;
    logic       wrap;
    logic       raw;
    logic       inset;
    logic [7:0] dattr;
    logic [6:0] last_col;
    logic [5:0] last_line;
  } cfg_t;

endpackage

### design/tw_ram.sv
module tw_ram #(
  parameter int WIDTH = tw_pkg::CELL_W,
  parameter int DEPTH = tw_pkg::MAX_COLS_DEF * tw_pkg::MAX_LINES_DEF
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_data_r <= mem_r[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

### design/tw_cfg.sv
module tw_cfg (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_psel,
  input  logic                      cfg_penable,
  input  logic                      cfg_pwrite,
  input  logic [tw_pkg::CFG_AW-1:0] cfg_paddr,
  input  logic [tw_pkg::CFG_DW-1:0] cfg_pwdata,
  output logic [tw_pkg::CFG_DW-1:0] cfg_prdata,
  output logic                      cfg_pready,
  output tw_pkg::cfg_t              cfg
);
  import tw_pkg::*;

  reg_idx_t   idx;
  logic       wr_en;
  logic [3:0] mode_r;
  logic [7:0] attr_r;
  logic [6:0] last_col_r;
  logic [5:0] last_line_r;

  assign idx        = reg_idx_t'(cfg_paddr[CFG_AW-1:2]);
  assign wr_en      = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_pready = 1'b1;

  // Register writes in the access phase.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= MODE_RESET;
      attr_r      <= ATTR_RESET;
      last_col_r  <= LAST_COL_RESET;
      last_line_r <= LAST_LINE_RESET;
    end else if (wr_en) begin
      unique case (idx)
        REG_MODE:      mode_r      <= cfg_pwdata[3:0];
        REG_ATTR:      attr_r      <= cfg_pwdata[7:0];
        REG_LAST_COL:  last_col_r  <= cfg_pwdata[6:0];
        REG_LAST_LINE: last_line_r <= cfg_pwdata[5:0];
        default: ;
      endcase
    end
  end

  // Read-back mux.
  always_comb begin
    unique case (idx)
      REG_MODE:      cfg_prdata = CFG_DW'(mode_r);
      REG_ATTR:      cfg_prdata = CFG_DW'(attr_r);
      REG_LAST_COL:  cfg_prdata = CFG_DW'(last_col_r);
      REG_LAST_LINE: cfg_prdata = CFG_DW'(last_line_r);
      default:       cfg_prdata = '0;
    endcase
  end

  assign cfg = '{scroll:    mode_r[3],
                 wrap:      mode_r[2],
                 raw:       mode_r[1],
                 inset:     mode_r[0],
                 dattr:     attr_r,
                 last_col:  last_col_r,
                 last_line: last_line_r};

endmodule

### design/tw_engine.sv
module tw_engine #(
  parameter int MAX_COLS  = tw_pkg::MAX_COLS_DEF,
  parameter int MAX_LINES = tw_pkg::MAX_LINES_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  input  tw_pkg::cfg_t cfg,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic         in_opcode,
  input  logic [7:0]   in_char_code,
  input  logic [7:0]   in_char_attr,
  input  logic [5:0]   in_read_line,
  input  logic [6:0]   in_read_col,
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic         out_status,
  output logic [5:0]   out_cursor_line,
  output logic [6:0]   out_cursor_col,
  output logic [7:0]   out_cell_char,
  output logic [7:0]   out_cell_attr,
  output logic         out_cell_line_changed
);
  import tw_pkg::*;

  localparam int COL_W  = $clog2(MAX_COLS);
  localparam int LINE_W = $clog2(MAX_LINES);
  localparam int AW     = LINE_W + COL_W;
  localparam int DEPTH  = 1 << AW;
  localparam int MDEPTH = 1 << LINE_W;

  localparam logic [8:0]       COLS_LIM  = 9'(MAX_COLS);
  localparam logic [8:0]       LINES_LIM = 9'(MAX_LINES);
  localparam logic [8:0]       COL_TOP9  = 9'(MAX_COLS - 1);
  localparam logic [8:0]       LINE_TOP9 = 9'(MAX_LINES - 1);
  localparam logic [6:0]       COL_TOP   = 7'(MAX_COLS - 1);
  localparam logic [5:0]       LINE_TOP  = 6'(MAX_LINES - 1);
  localparam logic [COL_W-1:0] CP_LAST   = COL_W'(MAX_COLS - 1);

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_RDWAIT,
    S_PUT,
    S_ADV,
    S_FILL,
    S_SCOPY,
    S_SDRAIN,
    S_SCLR,
    S_DONE
  } state_t;

  state_t                 state_r;
  logic [AW-1:0]          clr_addr_r;
  logic [5:0]             cur_line_r;
  logic [6:0]             cur_col_r;
  logic [7:0]             code_r;
  logic [7:0]             attr_r;
  logic                   lit_r;
  logic                   pend_r;
  logic                   status_r;
  logic                   rd_ok_r;
  logic                   rd_chg_r;
  logic [7:0]             cell_char_r;
  logic [7:0]             cell_attr_r;
  logic [5:0]             fill_line_r;
  logic [6:0]             fill_col_r;
  logic [6:0]             fill_last_r;
  logic [CELL_W-1:0]      fill_data_r;
  logic [6:0]             col_after_r;
  logic                   fill_adv_r;
  logic                   adv_skip_r;
  logic [5:0]             src_line_r;
  logic [COL_W-1:0]       cp_col_r;
  logic                   wp_r;
  logic [5:0]             wline_r;
  logic [COL_W-1:0]       wcol_r;
  logic                   out_valid_r;
  logic                   out_status_r;
  logic [5:0]             out_line_r;
  logic [6:0]             out_col_r;
  logic [7:0]             out_char_r;
  logic [7:0]             out_attr_r;
  logic                   out_chg_r;

  logic                   ram_we;
  logic [AW-1:0]          ram_waddr;
  logic [CELL_W-1:0]      ram_wdata;
  logic [AW-1:0]          ram_raddr;
  logic [CELL_W-1:0]      ram_rdata;

  logic                   mark_we;
  logic [LINE_W-1:0]      mark_waddr;
  logic [0:0]             mark_wdata;
  logic [LINE_W-1:0]      mark_raddr;
  logic [0:0]             mark_rdata;

  logic                   b;
  logic [6:0]             maxc;
  logic [5:0]             maxl;
  logic [6:0]             lastc;
  logic [5:0]             bottom;
  logic [7:0]             col_b;
  logic [6:0]             line_b;
  logic                   pos_ok;
  logic                   col_room;
  logic                   line_room;
  logic [6:0]             tab_v;
  logic [7:0]             tab_t;
  logic                   tab_fits;
  logic                   is_print;
  logic                   is_ctrl_pair;
  logic                   plain_now;
  logic [7:0]             put_char;
  logic [7:0]             caret_second;
  logic                   sclr_ok;
  logic [LINE_W-1:0]      line_idx;

  // Window limits clamped to the store, and cursor position tests.
  assign b      = cfg.inset;
  assign maxc   = (9'(cfg.last_col) > COL_TOP9) ? COL_TOP : cfg.last_col;
  assign maxl   = (9'(cfg.last_line) > LINE_TOP9) ? LINE_TOP : cfg.last_line;
  assign lastc  = maxc - 7'(b);
  assign bottom = maxl - 6'(b);
  assign col_b  = {1'b0, cur_col_r} + 8'(b);
  assign line_b = {1'b0, cur_line_r} + 7'(b);

  assign pos_ok    = (col_b <= {1'b0, maxc}) && (line_b <= {1'b0, maxl});
  assign col_room  = col_b < {1'b0, maxc};
  assign line_room = line_b < {1'b0, maxl};
  assign line_idx  = LINE_W'(cur_line_r);

  // Next tab stop, counted from the inset column.
  assign tab_v    = cur_col_r - 7'(b);
  assign tab_t    = (cur_col_r >= 7'(b)) ? (({1'b0, tab_v} & TAB_MASK) + TAB_STEP + 8'(b))
                                         : 8'(b);
  assign tab_fits = (tab_t + 8'(b)) <= {1'b0, maxc};

  // Character classes; the second code of a caret pair is always written plain.
  assign is_print     = ((code_r >= CH_BANG) && (code_r <= CH_TILDE)) || (code_r == CH_SPACE);
  assign is_ctrl_pair = !lit_r && !is_print && !cfg.raw && (code_r != CH_NL) &&
                        (code_r != CH_TAB) && (code_r != CH_BS);
  assign plain_now    = lit_r || is_print || (cfg.raw && (code_r != CH_NL)) || is_ctrl_pair;
  assign put_char     = is_ctrl_pair ? CH_CARET : code_r;
  assign caret_second = (code_r == CH_ALL) ? CH_QUEST : (code_r + CH_AT);

  // The bottom line is blanked after a scroll only if it lies inside the window.
  assign sclr_ok = !b || ((bottom != 6'd0) && (maxc >= 7'd2));

  assign in_tready = (state_r == S_IDLE);

  // Store port drive for each step of the sequencer.
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = '0;
    ram_wdata = '0;
    ram_raddr = '0;
    unique case (state_r)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_addr_r;
        ram_wdata = {8'h00, CH_SPACE};
      end
      S_IDLE: begin
        ram_raddr = {LINE_W'(in_read_line), COL_W'(in_read_col)};
      end
      S_PUT: begin
        ram_we    = pos_ok && plain_now;
        ram_waddr = {line_idx, COL_W'(cur_col_r)};
        ram_wdata = {attr_r, put_char};
      end
      S_FILL: begin
        ram_we    = 1'b1;
        ram_waddr = {LINE_W'(fill_line_r), COL_W'(fill_col_r)};
        ram_wdata = fill_data_r;
      end
      S_SCOPY: begin
        ram_raddr = {LINE_W'(src_line_r), cp_col_r};
      end
      default: ;
    endcase
    // Scroll copy: the cell read last cycle lands one line up.
    if (wp_r) begin
      ram_we    = 1'b1;
      ram_waddr = {LINE_W'(wline_r), wcol_r};
      ram_wdata = ram_rdata;
    end
  end

  // Line mark port drive: cleared with the store, set by every line that is written.
  always_comb begin
    mark_we    = 1'b0;
    mark_waddr = '0;
    mark_wdata = 1'b1;
    mark_raddr = '0;
    unique case (state_r)
      S_CLEAR: begin
        mark_we    = 1'b1;
        mark_waddr = clr_addr_r[AW-1:COL_W];
        mark_wdata = 1'b0;
      end
      S_IDLE: begin
        mark_raddr = LINE_W'(in_read_line);
      end
      S_PUT: begin
        mark_we    = pos_ok && (plain_now || (code_r == CH_NL) || (code_r == CH_TAB));
        mark_waddr = line_idx;
      end
      S_SCOPY: begin
        // Each line that a lower line moves up into is marked while it is copied.
        mark_we    = 1'b1;
        mark_waddr = LINE_W'(src_line_r - 6'd1);
      end
      S_SCLR: begin
        mark_we    = sclr_ok;
        mark_waddr = LINE_W'(bottom);
      end
      default: ;
    endcase
  end

  tw_ram #(
    .WIDTH(CELL_W),
    .DEPTH(DEPTH)
  ) u_store (
    .clk    (clk),
    .wr_en  (ram_we),
    .wr_addr(ram_waddr),
    .wr_data(ram_wdata),
    .rd_addr(ram_raddr),
    .rd_data(ram_rdata)
  );

  tw_ram #(
    .WIDTH(1),
    .DEPTH(MDEPTH)
  ) u_marks (
    .clk    (clk),
    .wr_en  (mark_we),
    .wr_addr(mark_waddr),
    .wr_data(mark_wdata),
    .rd_addr(mark_raddr),
    .rd_data(mark_rdata)
  );

  // Sequencer, cursor and result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_addr_r  <= '0;
      cur_line_r  <= '0;
      cur_col_r   <= '0;
      lit_r       <= 1'b0;
      pend_r      <= 1'b0;
      wp_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      wp_r <= (state_r == S_SCOPY);
      // The result register empties when taken, unless a new result replaces it.
      if (out_valid_r && out_tready && (state_r != S_DONE)) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_CLEAR: begin
          clr_addr_r <= clr_addr_r + 1'b1;
          if (clr_addr_r == {AW{1'b1}}) begin
            state_r <= S_IDLE;
          end
        end

        S_IDLE: begin
          if (in_tvalid) begin
            code_r      <= in_char_code;
            attr_r      <= in_char_attr | cfg.dattr;
            lit_r       <= 1'b0;
            pend_r      <= 1'b0;
            status_r    <= 1'b0;
            cell_char_r <= '0;
            cell_attr_r <= '0;
            rd_ok_r     <= (9'(in_read_line) < LINES_LIM) && (9'(in_read_col) < COLS_LIM);
            rd_chg_r    <= 1'b0;
            if (in_opcode == OP_READ) begin
              state_r <= S_RDWAIT;
            end else begin
              state_r <= S_PUT;
            end
          end
        end

        S_RDWAIT: begin
          if (rd_ok_r) begin
            cell_char_r <= ram_rdata[7:0];
            cell_attr_r <= ram_rdata[15:8];
            rd_chg_r    <= mark_rdata[0];
          end
          state_r <= S_DONE;
        end

        S_PUT: begin
          if (!pos_ok) begin
            status_r <= 1'b1;
            state_r  <= S_DONE;
          end else if (plain_now) begin
            // Cell written by the port drive; a caret pair queues its second code.
            pend_r <= is_ctrl_pair;
            lit_r  <= is_ctrl_pair;
            if (is_ctrl_pair) begin
              code_r <= caret_second;
            end
            adv_skip_r <= 1'b0;
            state_r    <= S_ADV;
          end else if (code_r == CH_NL) begin
            fill_line_r <= cur_line_r;
            fill_col_r  <= cur_col_r;
            fill_last_r <= lastc;
            fill_data_r <= {cfg.dattr, CH_SPACE};
            col_after_r <= cur_col_r;
            fill_adv_r  <= 1'b1;
            adv_skip_r  <= 1'b1;
            state_r     <= S_FILL;
          end else if (code_r == CH_TAB) begin
            fill_line_r <= cur_line_r;
            fill_col_r  <= cur_col_r;
            fill_data_r <= {attr_r, CH_SPACE};
            adv_skip_r  <= 1'b0;
            if (tab_fits) begin
              fill_last_r <= 7'(tab_t - 8'd1);
              col_after_r <= 7'(tab_t);
              fill_adv_r  <= 1'b0;
            end else begin
              fill_last_r <= lastc;
              col_after_r <= lastc;
              fill_adv_r  <= 1'b1;
            end
            state_r <= S_FILL;
          end else begin
            // Backspace.
            if (cur_col_r > 7'(b)) begin
              cur_col_r <= cur_col_r - 7'd1;
            end else if (cur_line_r > 6'(b)) begin
              cur_col_r  <= lastc;
              cur_line_r <= cur_line_r - 6'd1;
            end else begin
              status_r <= 1'b1;
            end
            state_r <= S_DONE;
          end
        end

        S_ADV: begin
          if (!adv_skip_r && col_room) begin
            cur_col_r <= cur_col_r + 7'd1;
            if (pend_r) begin
              pend_r  <= 1'b0;
              state_r <= S_PUT;
            end else begin
              state_r <= S_DONE;
            end
          end else if (!adv_skip_r && !cfg.wrap) begin
            status_r <= 1'b1;
            state_r  <= S_DONE;
          end else if (line_room) begin
            cur_line_r <= cur_line_r + 6'd1;
            cur_col_r  <= 7'(b);
            if (pend_r) begin
              pend_r  <= 1'b0;
              state_r <= S_PUT;
            end else begin
              state_r <= S_DONE;
            end
          end else if (cfg.scroll) begin
            src_line_r <= 6'(b) + 6'd1;
            cp_col_r   <= '0;
            state_r    <= (bottom > 6'(b)) ? S_SCOPY : S_SCLR;
          end else if (pend_r) begin
            pend_r  <= 1'b0;
            state_r <= S_PUT;
          end else begin
            state_r <= S_DONE;
          end
        end

        S_FILL: begin
          if (fill_col_r == fill_last_r) begin
            cur_col_r <= col_after_r;
            if (fill_adv_r) begin
              state_r <= S_ADV;
            end else if (pend_r) begin
              pend_r  <= 1'b0;
              state_r <= S_PUT;
            end else begin
              state_r <= S_DONE;
            end
          end else begin
            fill_col_r <= fill_col_r + 7'd1;
          end
        end

        S_SCOPY: begin
          wline_r <= src_line_r - 6'd1;
          wcol_r  <= cp_col_r;
          if (cp_col_r == CP_LAST) begin
            cp_col_r <= '0;
            if (src_line_r == bottom) begin
              state_r <= S_SDRAIN;
            end else begin
              src_line_r <= src_line_r + 6'd1;
            end
          end else begin
            cp_col_r <= cp_col_r + 1'b1;
          end
        end

        S_SDRAIN: begin
          state_r <= S_SCLR;
        end

        S_SCLR: begin
          if (sclr_ok) begin
            fill_line_r <= bottom;
            fill_col_r  <= 7'(b);
            fill_last_r <= lastc;
            fill_data_r <= {8'h00, CH_SPACE};
            col_after_r <= 7'(b);
            fill_adv_r  <= 1'b0;
            state_r     <= S_FILL;
          end else begin
            cur_col_r <= 7'(b);
            if (pend_r) begin
              pend_r  <= 1'b0;
              state_r <= S_PUT;
            end else begin
              state_r <= S_DONE;
            end
          end
        end

        S_DONE: begin
          if (!out_valid_r || out_tready) begin
            out_valid_r  <= 1'b1;
            out_status_r <= status_r;
            out_line_r   <= cur_line_r;
            out_col_r    <= cur_col_r;
            out_char_r   <= cell_char_r;
            out_attr_r   <= cell_attr_r;
            out_chg_r    <= rd_chg_r;
            state_r      <= S_IDLE;
          end
        end

        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_tvalid            = out_valid_r;
  assign out_status            = out_status_r;
  assign out_cursor_line       = out_line_r;
  assign out_cursor_col        = out_col_r;
  assign out_cell_char         = out_char_r;
  assign out_cell_attr         = out_attr_r;
  assign out_cell_line_changed = out_chg_r;

`ifndef SYNTH
  // The store is never written while a new item may be taken.
  a_idle_no_write: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> !ram_we)
    else $error("store written while idle");

  // Copy writes only follow copy reads.
  a_copy_write: assert property (@(posedge clk) disable iff (!rst_n)
    wp_r |-> (state_r == S_SCOPY || state_r == S_SDRAIN))
    else $error("copy write outside scroll");

  // A result appears only from the completion step.
  a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_DONE))
    else $error("result loaded outside completion");

  // A fill never runs past its last column.
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_FILL |-> fill_col_r <= fill_last_r)
    else $error("fill column past its end");
`endif

endmodule

### design/text_window_char_writer.sv
// Text window engine: a store of character and attribute cells, one changed mark per
// line and a cursor, driven by put and read items on a stream port and configured over
// a register port. All work goes through a sequencer around a store memory with one
// write and one registered read port and a small line mark memory of the same kind, so
// items are handled one at a time. A read is accepted, waits for the registered store
// and mark read, and then loads its result; a printable character is accepted, written
// to the store, the cursor is updated and the result is loaded. Newline blanks the rest
// of the line before the cursor update; a tab that reaches its stop blanks cells in place
// of the cursor update. A scroll copies every column of each moved line at one cell per
// cycle, passes a drain step and a clear step and then blanks the bottom line of the
// window one cell per cycle. After reset a clearing pass writes spaces to the whole store
// and clears the line marks, one cell per cycle; no item is taken during it, while
// register writes are. A finished result waits in an output register, and the next item
// is taken meanwhile.
module text_window_char_writer #(
  parameter int MAX_COLS  = tw_pkg::MAX_COLS_DEF,
  parameter int MAX_LINES = tw_pkg::MAX_LINES_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  // Input items.
  input  logic                      in_tvalid,
  output logic                      in_tready,
  // char_code[7:0], char_attr[15:8], read_line[21:16], read_col[28:22], zero[31:29]
  input  logic [tw_pkg::IN_DW-1:0]  in_tdata,
  // opcode[0]
  input  logic [0:0]                in_tuser,
  // Result items.
  output logic                      out_tvalid,
  input  logic                      out_tready,
  // status[0], cursor_line[6:1], cursor_col[13:7], cell_char[21:14],
  // cell_attr[29:22], cell_line_changed[30], zero[31]
  output logic [tw_pkg::OUT_DW-1:0] out_tdata,
  // Register port.
  input  logic                      cfg_psel,
  input  logic                      cfg_penable,
  input  logic                      cfg_pwrite,
  input  logic [tw_pkg::CFG_AW-1:0] cfg_paddr,
  input  logic [tw_pkg::CFG_DW-1:0] cfg_pwdata,
  output logic [tw_pkg::CFG_DW-1:0] cfg_prdata,
  output logic                      cfg_pready
);
  import tw_pkg::*;

  cfg_t       cfg;
  logic       res_status;
  logic [5:0] res_line;
  logic [6:0] res_col;
  logic [7:0] res_char;
  logic [7:0] res_attr;
  logic       res_chg;

  tw_cfg u_cfg (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready),
    .cfg        (cfg)
  );

  tw_engine #(
    .MAX_COLS (MAX_COLS),
    .MAX_LINES(MAX_LINES)
  ) u_engine (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cfg                  (cfg),
    .in_tvalid            (in_tvalid),
    .in_tready            (in_tready),
    .in_opcode            (in_tuser[0]),
    .in_char_code         (in_tdata[7:0]),
    .in_char_attr         (in_tdata[15:8]),
    .in_read_line         (in_tdata[21:16]),
    .in_read_col          (in_tdata[28:22]),
    .out_tvalid           (out_tvalid),
    .out_tready           (out_tready),
    .out_status           (res_status),
    .out_cursor_line      (res_line),
    .out_cursor_col       (res_col),
    .out_cell_char        (res_char),
    .out_cell_attr        (res_attr),
    .out_cell_line_changed(res_chg)
  );

  // Pack the result fields, lowest field first.
  assign out_tdata = {1'b0, res_chg, res_attr, res_char, res_col, res_line, res_status};

endmodule

### tb/testbench.sv
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import tw_pkg::*;

  localparam int MAXC = MAX_COLS_DEF;
  localparam int MAXL = MAX_LINES_DEF;
  localparam int TABW = int'(TAB_STEP);
  localparam int LIMIT_NS = 100_000_000;

  // One input item; the opcode travels in tuser, the rest in tdata.
  typedef struct packed {
    logic       op;
    logic [6:0] rcol;
    logic [5:0] rline;
    logic [7:0] attr;
    logic [7:0] code;
  } win_item_t;

  // One result item, laid out like out_tdata[30:0].
  typedef struct packed {
    logic       chg;
    logic [7:0] cattr;
    logic [7:0] cchar;
    logic [6:0] ccol;
    logic [5:0] cline;
    logic       status;
  } win_result_t;

  // One row of the directed table: either a register setting or an item.
  typedef struct {
    bit          is_cfg;
    bit          typed;
    win_item_t   it;
    win_result_t want;
    logic [3:0]  mode;
    logic [7:0]  dattr;
    logic [6:0]  lcol;
    logic [5:0]  lline;
  } dir_row_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_tvalid = 1'b0;
  logic                in_tready;
  logic [IN_DW-1:0]    in_tdata = '0;
  logic [0:0]          in_tuser = '0;
  logic                out_tvalid;
  logic                out_tready = 1'b0;
  logic [OUT_DW-1:0]   out_tdata;
  logic                cfg_psel = 1'b0;
  logic                cfg_penable = 1'b0;
  logic                cfg_pwrite = 1'b0;
  logic [CFG_AW-1:0]   cfg_paddr = '0;
  logic [CFG_DW-1:0]   cfg_pwdata = '0;
  logic [CFG_DW-1:0]   cfg_prdata;
  logic                cfg_pready;

  text_window_char_writer u_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always #1 clk = ~clk;

  // Shadow copy of the window: cells, line marks, cursor and registers.
  logic [15:0] shadow_cells [0:MAXC*MAXL-1];
  bit          shadow_marks [0:MAXL-1];
  int          shadow_line;
  int          shadow_col;
  logic [3:0]  w_mode;
  logic [7:0]  w_dattr;
  logic [6:0]  w_last_col;
  logic [5:0]  w_last_line;

  win_result_t pending_results [$];
  dir_row_t    dir_rows [$];
  int          err_count = 0;
  int          idle_mode = 0;
  win_result_t rx_got;
  win_result_t rx_want;

  function automatic int tx_idle_pct();
    return (idle_mode == 0) ? 37 : (idle_mode == 1) ? 79 : 0;
  endfunction

  function automatic int rx_idle_pct();
    return (idle_mode == 0) ? 79 : (idle_mode == 1) ? 37 : 0;
  endfunction

  function automatic int win_col();
    return (int'(w_last_col) > MAXC - 1) ? MAXC - 1 : int'(w_last_col);
  endfunction

  function automatic int win_line();
    return (int'(w_last_line) > MAXL - 1) ? MAXL - 1 : int'(w_last_line);
  endfunction

  function automatic int inset_w();
    return w_mode[0] ? 1 : 0;
  endfunction

  function automatic void store_cell(int ln, int col, logic [7:0] ch, logic [7:0] at);
    if (ln < 0 || ln >= MAXL || col < 0 || col >= MAXC) return;
    shadow_cells[ln*MAXC + col] = {at, ch};
    shadow_marks[ln] = 1'b1;
  endfunction

  function automatic bit cursor_in_window();
    int b;
    b = inset_w();
    return shadow_col <= win_col() - b && shadow_line <= win_line() - b;
  endfunction

  // Move lines of the window up by one and blank the bottom line.
  function automatic void scroll_up();
    int b, bottom;
    b = inset_w();
    bottom = win_line() - b;
    for (int l = b; l < bottom; l++) begin
      for (int c = 0; c < MAXC; c++)
        shadow_cells[l*MAXC + c] = shadow_cells[(l+1)*MAXC + c];
      shadow_marks[l] = 1'b1;
    end
    if (bottom >= b)
      for (int c = b; c <= win_col() - b; c++)
        store_cell(bottom, c, CH_SPACE, 8'h00);
  endfunction

  // Cursor advance with wrap and scroll; returns the error flag.
  function automatic bit step_cursor(bit no_wrap);
    int b;
    b = inset_w();
    if (!no_wrap) begin
      if (shadow_col < win_col() - b) begin
        shadow_col++;
        return 1'b0;
      end
      if (!w_mode[2]) return 1'b1;
    end
    if (shadow_line < win_line() - b) begin
      shadow_line++;
      shadow_col = b;
    end else if (w_mode[3]) begin
      scroll_up();
      shadow_col = b;
    end
    return 1'b0;
  endfunction

  function automatic bit put_glyph(logic [7:0] ch, logic [7:0] at);
    if (!cursor_in_window()) return 1'b1;
    store_cell(shadow_line, shadow_col, ch, at);
    return step_cursor(1'b0);
  endfunction

  // One put item: printable, newline, raw, tab, backspace or caret pair.
  function automatic bit put_char(logic [7:0] c, logic [7:0] at);
    int b, maxc, v, t;
    logic [7:0] second;
    b = inset_w();
    maxc = win_col();
    if (!cursor_in_window()) return 1'b1;
    if ((c >= CH_BANG && c <= CH_TILDE) || c == CH_SPACE) return put_glyph(c, at);
    if (c == CH_NL) begin
      for (int i = shadow_col; i <= maxc - b; i++)
        store_cell(shadow_line, i, CH_SPACE, w_dattr);
      if (shadow_line >= 0 && shadow_line < MAXL) shadow_marks[shadow_line] = 1'b1;
      return step_cursor(1'b1);
    end
    if (w_mode[1]) return put_glyph(c, at);
    if (c == CH_TAB) begin
      v = shadow_col - b;
      t = ((v >= 0) ? (v - v % TABW) : -TABW) + TABW + b;
      if (t <= maxc - b) begin
        for (int i = shadow_col; i < t; i++)
          store_cell(shadow_line, i, CH_SPACE, at);
        shadow_col = t;
        return 1'b0;
      end
      for (int i = shadow_col; i <= maxc - b; i++)
        store_cell(shadow_line, i, CH_SPACE, at);
      shadow_col = maxc - b;
      return step_cursor(1'b0);
    end
    if (c == CH_BS) begin
      if (shadow_col > b) begin
        shadow_col--;
      end else if (shadow_line > b) begin
        shadow_col = maxc - b;
        shadow_line--;
      end else begin
        return 1'b1;
      end
      return 1'b0;
    end
    if (put_glyph(CH_CARET, at)) return 1'b1;
    second = (c == CH_ALL) ? CH_QUEST : 8'(c + CH_AT);
    return put_glyph(second, at);
  endfunction

  // Applies one item to the shadow window and returns its result.
  function automatic win_result_t window_step(win_item_t it);
    win_result_t r;
    logic [15:0] cell_word;
    r = '0;
    if (it.op == OP_PUT) begin
      r.status = put_char(it.code, it.attr | w_dattr);
    end else begin
      cell_word = shadow_cells[int'(it.rline)*MAXC + int'(it.rcol)];
      r.cchar = cell_word[7:0];
      r.cattr = cell_word[15:8];
      r.chg = shadow_marks[it.rline];
    end
    r.cline = 6'(shadow_line);
    r.ccol = 7'(shadow_col);
    return r;
  endfunction

  function automatic win_item_t random_item();
    win_item_t it;
    int k;
    it.op = OP_PUT;
    it.code = 8'($urandom_range(0, 255));
    it.attr = 8'($urandom_range(0, 255));
    it.rline = 6'($urandom_range(0, 63));
    it.rcol = 7'($urandom_range(0, 127));
    k = $urandom_range(0, 99);
    if (k < 45) it.code = 8'($urandom_range(int'(CH_TILDE), int'(CH_SPACE)));
    else if (k < 55) it.code = CH_NL;
    else if (k < 63) it.code = CH_TAB;
    else if (k < 71) it.code = CH_BS;
    else if (k >= 80) begin
      it.op = OP_READ;
      // Mostly read inside the window, where the writes land.
      if ($urandom_range(0, 3) != 0) begin
        it.rline = 6'($urandom_range(0, win_line()));
        it.rcol = 7'($urandom_range(0, win_col()));
      end
    end
    return it;
  endfunction

  function automatic dir_row_t put_row(logic [7:0] code, logic [7:0] attr);
    dir_row_t r;
    r = '{default: '0};
    r.it.op = OP_PUT;
    r.it.code = code;
    r.it.attr = attr;
    return r;
  endfunction

  function automatic dir_row_t read_row(int ln, int col);
    dir_row_t r;
    r = '{default: '0};
    r.it.op = OP_READ;
    r.it.rline = 6'(ln);
    r.it.rcol = 7'(col);
    return r;
  endfunction

  function automatic dir_row_t cfg_row(logic [3:0] m, logic [7:0] a, int lc, int ll);
    dir_row_t r;
    r = '{default: '0};
    r.is_cfg = 1'b1;
    r.mode = m;
    r.dattr = a;
    r.lcol = 7'(lc);
    r.lline = 6'(ll);
    return r;
  endfunction

  function automatic dir_row_t typed(dir_row_t r, logic st, int cl, int cc,
                                     logic [7:0] ch, logic [7:0] at, logic chg);
    r.typed = 1'b1;
    r.want.status = st;
    r.want.cline = 6'(cl);
    r.want.ccol = 7'(cc);
    r.want.cchar = ch;
    r.want.cattr = at;
    r.want.chg = chg;
    return r;
  endfunction

  task automatic report_mismatch(string what, int unsigned want, int unsigned got);
    err_count++;
    if (err_count <= 40)
      $display("mismatch at %0t: %s expected %0h got %0h", $realtime, what, want, got);
  endtask

  // Sends one item after a random gap and records its expected result.
  task automatic drive_item(win_item_t it, bit use_typed, win_result_t want);
    win_result_t pred;
    while ($urandom_range(0, 99) < tx_idle_pct()) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {3'b000, it.rcol, it.rline, it.attr, it.code};
    in_tuser <= it.op;
    do @(posedge clk); while (!in_tready);
    pred = window_step(it);
    pending_results.push_back(use_typed ? want : pred);
  endtask

  // Holds off the sender until every expected result has come back.
  task automatic wait_results_done();
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Writes all four registers, each with a setup and an access phase.
  task automatic cfg_apply(logic [3:0] m, logic [7:0] a, logic [6:0] lc, logic [5:0] ll);
    logic [31:0] vals [4];
    vals[REG_MODE] = {28'd0, m};
    vals[REG_ATTR] = {24'd0, a};
    vals[REG_LAST_COL] = {25'd0, lc};
    vals[REG_LAST_LINE] = {26'd0, ll};
    for (int i = 0; i < 4; i++) begin
      cfg_psel <= 1'b1;
      cfg_penable <= 1'b0;
      cfg_pwrite <= 1'b1;
      cfg_paddr <= {reg_idx_t'(i), 2'b00};
      cfg_pwdata <= vals[i];
      @(posedge clk);
      cfg_penable <= 1'b1;
      do @(posedge clk); while (!cfg_pready);
    end
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    w_mode = m;
    w_dattr = a;
    w_last_col = lc;
    w_last_line = ll;
  endtask

  // Result checking and receiver stalls.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      rx_got = out_tdata[30:0];
      if (pending_results.size() == 0) begin
        report_mismatch("result with nothing expected", 0, rx_got);
      end else begin
        rx_want = pending_results.pop_front();
        if (rx_got.status != rx_want.status)
          report_mismatch("status", rx_want.status, rx_got.status);
        if (rx_got.cline != rx_want.cline)
          report_mismatch("cursor_line", rx_want.cline, rx_got.cline);
        if (rx_got.ccol != rx_want.ccol)
          report_mismatch("cursor_col", rx_want.ccol, rx_got.ccol);
        if (rx_got.cchar != rx_want.cchar)
          report_mismatch("cell_char", rx_want.cchar, rx_got.cchar);
        if (rx_got.cattr != rx_want.cattr)
          report_mismatch("cell_attr", rx_want.cattr, rx_got.cattr);
        if (rx_got.chg != rx_want.chg)
          report_mismatch("cell_line_changed", rx_want.chg, rx_got.chg);
      end
    end
    out_tready <= ($urandom_range(0, 99) >= rx_idle_pct());
  end

  // Run limit.
  initial begin
    #(LIMIT_NS);
    $display("TEST FAILED");
    $finish;
  end

  // Stimulus: reset, directed table, then random phases of register settings.
  initial begin
    int n, lc, ll, need;
    logic [3:0] m;
    logic [7:0] a;

    for (int i = 0; i < MAXC*MAXL; i++) shadow_cells[i] = {8'h00, CH_SPACE};
    for (int i = 0; i < MAXL; i++) shadow_marks[i] = 1'b0;
    shadow_line = 0;
    shadow_col = 0;
    w_mode = MODE_RESET;
    w_dattr = ATTR_RESET;
    w_last_col = LAST_COL_RESET;
    w_last_line = LAST_LINE_RESET;

    // Directed table, starting from the reset settings.
    dir_rows.push_back(typed(read_row(0, 0), 1'b0, 0, 0, CH_SPACE, 8'h00, 1'b0));
    dir_rows.push_back(typed(put_row(8'h41, 8'h00), 1'b0, 0, 1, 8'h00, 8'h00, 1'b0));
    dir_rows.push_back(typed(read_row(0, 0), 1'b0, 0, 1, 8'h41, 8'h00, 1'b1));
    dir_rows.push_back(typed(put_row(CH_BS, 8'h00), 1'b0, 0, 0, 8'h00, 8'h00, 1'b0));
    // Backspace at the origin is an error.
    dir_rows.push_back(typed(put_row(CH_BS, 8'h00), 1'b1, 0, 0, 8'h00, 8'h00, 1'b0));
    dir_rows.push_back(put_row(CH_TILDE, 8'hFF));
    dir_rows.push_back(put_row(CH_BANG, 8'h00));
    dir_rows.push_back(put_row(CH_TAB, 8'h3C));
    dir_rows.push_back(put_row(8'h01, 8'h00));
    dir_rows.push_back(put_row(CH_ALL, 8'h81));
    dir_rows.push_back(put_row(8'hC5, 8'h00));
    dir_rows.push_back(put_row(CH_NL, 8'h00));
    dir_rows.push_back(read_row(0, 9));
    // Small inset window that leaves the cursor outside.
    dir_rows.push_back(cfg_row(4'hD, 8'hA5, 7, 1));
    dir_rows.push_back(put_row(8'h41, 8'h00));
    // Same window without inset: tab past the edge wraps and scrolls.
    dir_rows.push_back(cfg_row(4'hC, 8'hA5, 7, 1));
    dir_rows.push_back(put_row(CH_TAB, 8'h00));
    dir_rows.push_back(put_row(CH_NL, 8'h00));
    dir_rows.push_back(read_row(0, 7));
    // Largest window with raw control codes.
    dir_rows.push_back(cfg_row(4'h2, 8'h00, 127, 63));
    dir_rows.push_back(put_row(8'h01, 8'h5A));
    dir_rows.push_back(put_row(CH_ALL, 8'h00));
    dir_rows.push_back(put_row(CH_NL, 8'h00));
    dir_rows.push_back(read_row(63, 127));
    // Inset turned on with the cursor in column zero: tab stops at the inset.
    dir_rows.push_back(cfg_row(4'h5, 8'h0F, 20, 5));
    dir_rows.push_back(put_row(CH_TAB, 8'h00));
    dir_rows.push_back(put_row(CH_BS, 8'h00));
    dir_rows.push_back(put_row(8'h7A, 8'hF0));
    // Smallest window with inset: nothing fits.
    dir_rows.push_back(cfg_row(4'h1, 8'h00, 0, 0));
    dir_rows.push_back(put_row(8'h41, 8'h00));

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[i]) begin
      if (dir_rows[i].is_cfg) begin
        wait_results_done();
        cfg_apply(dir_rows[i].mode, dir_rows[i].dattr, dir_rows[i].lcol, dir_rows[i].lline);
      end else begin
        drive_item(dir_rows[i].it, dir_rows[i].typed, dir_rows[i].want);
      end
    end

    // Random phases, each under its own register setting.
    for (int ph = 0; ph < 12; ph++) begin
      wait_results_done();
      idle_mode = ph / 4;
      m = 4'($urandom_range(0, 15));
      a = ($urandom_range(0, 3) == 0) ? 8'h00 : 8'($urandom_range(0, 255));
      lc = $urandom_range(0, 23);
      ll = $urandom_range(0, 7);
      n = 70;
      if (ph == 5) m = 4'h0;
      if (ph == 7) m = 4'hF;
      if (ph == 3) begin
        lc = 0;
        ll = 0;
        n = 20;
      end else if (ph == 11) begin
        lc = 127;
        ll = 63;
        n = 40;
      end else if ($urandom_range(0, 3) != 0) begin
        // Usually grow the window so the cursor stays inside it.
        need = shadow_col + int'(m[0]);
        if (need > lc) lc = (need > 127) ? 127 : need;
        need = shadow_line + int'(m[0]);
        if (need > ll) ll = (need > 63) ? 63 : need;
      end
      cfg_apply(m, a, 7'(lc), 6'(ll));
      repeat (n) drive_item(random_item(), 1'b0, '0);
    end

    wait_results_done();
    repeat (16) @(posedge clk);
    if (err_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
